// ----- hw/rtl/swsa_pkg.sv -----
// Package: shared constants, state codes and the reciprocal table of the moving average core.
package swsa_pkg;

  // Ring geometry
  localparam int unsigned RING_DEPTH = 16;
  localparam int unsigned PTR_W      = $clog2(RING_DEPTH);
  localparam int unsigned CNT_W      = $clog2(RING_DEPTH + 1);

  // Field widths
  localparam int unsigned SMP_W  = 16;
  localparam int unsigned TOT_W  = 20;
  localparam int unsigned MEAN_W = 16;
  localparam int unsigned LEN_W  = 5;

  // Compare width for count vs. window length
  localparam int unsigned CMP_W = (CNT_W > LEN_W) ? CNT_W : LEN_W;

  // Internal sum: at most 16 samples of 16 bits, kept exact
  localparam int unsigned SUM_W = 22;

  // Reciprocal: ceil(2^RECIP_SH / d), exact for dividends below 2^24
  localparam int unsigned RECIP_SH = 29;
  localparam int unsigned RECIP_W  = 30;
  localparam int unsigned PROD_W   = SUM_W + RECIP_W;

  localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(10);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_SUM  = 4'b0010,
    ST_MUL  = 4'b0100,
    ST_DONE = 4'b1000
  } state_e;

  function automatic logic [RECIP_W-1:0] recip(input logic [LEN_W-1:0] d);
    logic [RECIP_W-1:0] r;
    case (d)
      5'd1:    r = 30'd536870912;
      5'd2:    r = 30'd268435456;
      5'd3:    r = 30'd178956971;
      5'd4:    r = 30'd134217728;
      5'd5:    r = 30'd107374183;
      5'd6:    r = 30'd89478486;
      5'd7:    r = 30'd76695845;
      5'd8:    r = 30'd67108864;
      5'd9:    r = 30'd59652324;
      5'd10:   r = 30'd53687092;
      5'd11:   r = 30'd48806447;
      5'd12:   r = 30'd44739243;
      5'd13:   r = 30'd41297763;
      5'd14:   r = 30'd38347923;
      5'd15:   r = 30'd35791395;
      5'd16:   r = 30'd33554432;
      5'd17:   r = 30'd31580642;
      5'd18:   r = 30'd29826162;
      5'd19:   r = 30'd28256364;
      5'd20:   r = 30'd26843546;
      5'd21:   r = 30'd25565282;
      5'd22:   r = 30'd24403224;
      5'd23:   r = 30'd23342214;
      5'd24:   r = 30'd22369622;
      5'd25:   r = 30'd21474837;
      5'd26:   r = 30'd20648882;
      5'd27:   r = 30'd19884108;
      5'd28:   r = 30'd19173962;
      5'd29:   r = 30'd18512791;
      5'd30:   r = 30'd17895698;
      5'd31:   r = 30'd17318417;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

// ----- hw/rtl/swsa_if.sv -----
// Interfaces: sample input channel and result output channel.
interface swsa_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [swsa_pkg::SMP_W-1:0]   sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface swsa_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [swsa_pkg::TOT_W-1:0]   window_total;
  logic signed [swsa_pkg::MEAN_W-1:0]  window_mean;
  logic        [swsa_pkg::LEN_W-1:0]   fill_level;

  modport source (output valid, output window_total, output window_mean,
                  output fill_level, input ready);
  modport sink   (input valid, input window_total, input window_mean,
                  input fill_level, output ready);
endinterface

// ----- hw/rtl/swsa_ram.sv -----
// Generic RAM: one write port, one read port, registered read, old data on collision.
module swsa_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hw/rtl/sliding_window_sum_average_core.sv -----
// Top level: boxcar moving average over signed Q8.8 samples, ring held in a RAM.
//
// Usage:
//   smp_i  : sample beats in (valid/ready, payload sample, signed Q8.8).
//   res_o  : one result beat per sample (window_total, window_mean, fill_level).
//   cfg_*  : write of window_len (1..16, values 0 and >RING_DEPTH are clamped).
//            A write empties the window; issue it only while the core is idle.
// Timing:
//   A sample is taken in ST_IDLE. The next cycle the evicted sample comes back
//   from the ring RAM and the running sum updates; the cycle after, the sum
//   magnitude is multiplied by a table reciprocal of the fill count; then the
//   result is loaded into the output register. The core takes no new sample
//   until it is back in ST_IDLE, after the RAM read-modify-write and the
//   registered multiply, so only one sample is in work at a time.
// Stall:
//   The output register holds a result while res_o.ready is low; the core
//   takes and processes the next sample meanwhile and waits in ST_DONE only
//   if the previous result has still not been taken.
// Reset:
//   rst_ni clears pointers, count, sum and window_len (to 10). The ring RAM
//   is not cleared: only entries written since the last clear are read back.
module sliding_window_sum_average_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [swsa_pkg::LEN_W-1:0]    cfg_wdata_i,
  swsa_in_if.sink                       smp_i,
  swsa_out_if.source                    res_o
);

  swsa_pkg::state_e state_q, state_d;

  logic [swsa_pkg::LEN_W-1:0]  win_len_q;
  logic [swsa_pkg::PTR_W-1:0]  wr_ptr_q, old_ptr_q;
  logic [swsa_pkg::CNT_W-1:0]  cnt_q;
  logic [swsa_pkg::SUM_W-1:0]  sum_q;
  logic                        evict_q;
  logic [swsa_pkg::SMP_W-1:0]  smp_q;
  logic [swsa_pkg::PROD_W-1:0] prod_q;
  logic                        neg_q;

  logic                        out_valid_q;
  logic [swsa_pkg::TOT_W-1:0]  tot_q;
  logic [swsa_pkg::MEAN_W-1:0] mean_q;
  logic [swsa_pkg::LEN_W-1:0]  fill_q;

  logic                        accept;
  logic                        evict;
  logic [swsa_pkg::CMP_W-1:0]  len_eff;
  logic [swsa_pkg::SMP_W-1:0]  ram_rdata;
  logic [swsa_pkg::SUM_W-1:0]  sum_d;
  logic [swsa_pkg::SUM_W-1:0]  mag;
  logic [swsa_pkg::MEAN_W-1:0] quot;
  logic                        load_out;

  // Clamp window length to 1..RING_DEPTH
  always_comb begin
    len_eff = swsa_pkg::CMP_W'(win_len_q);
    if (len_eff == '0) begin
      len_eff = swsa_pkg::CMP_W'(1);
    end else if (len_eff > swsa_pkg::CMP_W'(swsa_pkg::RING_DEPTH)) begin
      len_eff = swsa_pkg::CMP_W'(swsa_pkg::RING_DEPTH);
    end
  end

  assign smp_i.ready = (state_q == swsa_pkg::ST_IDLE) && !cfg_we_i;
  assign accept      = smp_i.valid && smp_i.ready;
  assign evict       = swsa_pkg::CMP_W'(cnt_q) >= len_eff;

  // Ring: read oldest and write newest on the same edge. When the window is as
  // deep as the ring both pointers match; the RAM returns the old entry then.
  swsa_ram #(
    .WIDTH (swsa_pkg::SMP_W),
    .DEPTH (swsa_pkg::RING_DEPTH)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (accept),
    .waddr_i (wr_ptr_q),
    .wdata_i (smp_i.sample),
    .raddr_i (old_ptr_q),
    .rdata_o (ram_rdata)
  );

  // Running sum: subtract evicted sample, add new one (both sign-extended)
  always_comb begin
    sum_d = sum_q + {{(swsa_pkg::SUM_W-swsa_pkg::SMP_W){smp_q[swsa_pkg::SMP_W-1]}}, smp_q};
    if (evict_q) begin
      sum_d = sum_d -
              {{(swsa_pkg::SUM_W-swsa_pkg::SMP_W){ram_rdata[swsa_pkg::SMP_W-1]}}, ram_rdata};
    end
  end

  // Divide by fill count: magnitude times reciprocal, sign restored after
  assign mag  = sum_q[swsa_pkg::SUM_W-1] ? (~sum_q + 1'b1) : sum_q;
  assign quot = prod_q[swsa_pkg::RECIP_SH +: swsa_pkg::MEAN_W];

  assign load_out = (state_q == swsa_pkg::ST_DONE) && (!out_valid_q || res_o.ready);

  always_comb begin
    state_d = state_q;
    case (state_q)
      swsa_pkg::ST_IDLE: if (accept) state_d = swsa_pkg::ST_SUM;
      swsa_pkg::ST_SUM:  state_d = swsa_pkg::ST_MUL;
      swsa_pkg::ST_MUL:  state_d = swsa_pkg::ST_DONE;
      swsa_pkg::ST_DONE: if (load_out) state_d = swsa_pkg::ST_IDLE;
      default:           state_d = swsa_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= swsa_pkg::ST_IDLE;
      win_len_q   <= swsa_pkg::LEN_RESET;
      wr_ptr_q    <= '0;
      old_ptr_q   <= '0;
      cnt_q       <= '0;
      sum_q       <= '0;
      evict_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;

      if (cfg_we_i) begin
        win_len_q <= cfg_wdata_i;
        wr_ptr_q  <= '0;
        old_ptr_q <= '0;
        cnt_q     <= '0;
        sum_q     <= '0;
      end else if (accept) begin
        evict_q  <= evict;
        wr_ptr_q <= (wr_ptr_q == swsa_pkg::PTR_W'(swsa_pkg::RING_DEPTH - 1)) ?
                    '0 : wr_ptr_q + 1'b1;
        if (evict) begin
          old_ptr_q <= (old_ptr_q == swsa_pkg::PTR_W'(swsa_pkg::RING_DEPTH - 1)) ?
                       '0 : old_ptr_q + 1'b1;
        end else begin
          cnt_q <= cnt_q + 1'b1;
        end
      end else if (state_q == swsa_pkg::ST_SUM) begin
        sum_q <= sum_d;
      end

      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Datapath registers, no reset
  always_ff @(posedge clk_i) begin
    if (accept) begin
      smp_q <= smp_i.sample;
    end
    if (state_q == swsa_pkg::ST_MUL) begin
      prod_q <= swsa_pkg::PROD_W'(mag) *
                swsa_pkg::PROD_W'(swsa_pkg::recip(swsa_pkg::LEN_W'(cnt_q)));
      neg_q  <= sum_q[swsa_pkg::SUM_W-1];
    end
    if (load_out) begin
      tot_q  <= sum_q[swsa_pkg::TOT_W-1:0];
      mean_q <= neg_q ? (~quot + 1'b1) : quot;
      fill_q <= swsa_pkg::LEN_W'(cnt_q);
    end
  end

  assign res_o.valid        = out_valid_q;
  assign res_o.window_total = tot_q;
  assign res_o.window_mean  = mean_q;
  assign res_o.fill_level   = fill_q;

endmodule

// ----- hw/rtl/swsa_checker.sv -----
// Checker: port-level assertions for the moving average core, bound to the top level.
module swsa_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_ready_i,
  input logic                          out_valid_i,
  input logic                          out_ready_i,
  input logic [swsa_pkg::TOT_W-1:0]    total_i,
  input logic [swsa_pkg::MEAN_W-1:0]   mean_i,
  input logic [swsa_pkg::LEN_W-1:0]    fill_i
);

  // Stalled result beat stays up
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result beat dropped while stalled");

  // Stalled result payload holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(total_i) && $stable(mean_i) && $stable(fill_i))
    else $error("result payload changed while stalled");

  // One sample in flight: no beat taken right after another
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("sample taken while previous still in work");

  // Fill level in 1..RING_DEPTH
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (fill_i != '0) && (int'(fill_i) <= swsa_pkg::RING_DEPTH))
    else $error("fill level out of range");

endmodule

bind sliding_window_sum_average_core swsa_checker u_swsa_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (smp_i.valid),
  .in_ready_i  (smp_i.ready),
  .out_valid_i (res_o.valid),
  .out_ready_i (res_o.ready),
  .total_i     (res_o.window_total),
  .mean_i      (res_o.window_mean),
  .fill_i      (res_o.fill_level)
);

// ----- bench/tb_top.sv -----
// Testbench for the moving average core: directed and random sample beats, model-checked.
`timescale 1ns / 100ps

module tb_top;

  // Beats that sit idle this long on both channels end the run.
  localparam int WATCHDOG_LIMIT = 2000;
  // Cycles allowed after the last result before a register write or the end.
  localparam int SETTLE_CYCLES  = 8;
  localparam int PHASES         = 13;
  localparam int PHASE_BEATS    = 85;

  typedef enum logic {ROW_CFG, ROW_SAMPLE} row_kind_e;

  typedef struct packed {
    logic signed [swsa_pkg::TOT_W-1:0]  total;
    logic signed [swsa_pkg::MEAN_W-1:0] mean;
    logic        [swsa_pkg::LEN_W-1:0]  fill;
  } window_result_t;

  // One line of the directed table: a register write, or a sample sent rep times.
  // Where typed is set, exp is the result of the last beat of the row.
  typedef struct {
    row_kind_e                         kind;
    logic [swsa_pkg::LEN_W-1:0]        len;
    logic signed [swsa_pkg::SMP_W-1:0] value;
    int                                rep;
    bit                                typed;
    window_result_t                    exp;
  } stim_row_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;
  logic                       cfg_we;
  logic [swsa_pkg::LEN_W-1:0] cfg_wdata;

  swsa_in_if  smp_bus ();
  swsa_out_if res_bus ();

  sliding_window_sum_average_core u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .smp_i       (smp_bus),
    .res_o       (res_bus)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Window model: its own ring, pointers, count and sum.
  // ---------------------------------------------------------------------------
  logic signed [swsa_pkg::SMP_W-1:0] win_ring [swsa_pkg::RING_DEPTH];
  logic [swsa_pkg::PTR_W-1:0]        win_head;   // oldest entry
  logic [swsa_pkg::PTR_W-1:0]        win_tail;   // next entry to write
  int                                win_fill;
  int                                win_sum;    // kept exact, shown as low TOT_W bits
  logic [swsa_pkg::LEN_W-1:0]        win_len;

  window_result_t expected_results [$];

  // Length 0 behaves as 1, anything past the ring as the ring depth.
  function automatic int window_span(input logic [swsa_pkg::LEN_W-1:0] len);
    int n;
    n = int'(len);
    if (n < 1) n = 1;
    if (n > int'(swsa_pkg::RING_DEPTH)) n = int'(swsa_pkg::RING_DEPTH);
    return n;
  endfunction

  // A register write sets the length and empties the window.
  function automatic void load_window_len(input logic [swsa_pkg::LEN_W-1:0] len);
    win_len  = len;
    win_head = '0;
    win_tail = '0;
    win_fill = 0;
    win_sum  = 0;
  endfunction

  // Evict the oldest sample first when full, so a 16-deep window stays exact.
  function automatic window_result_t advance_window(
    input logic signed [swsa_pkg::SMP_W-1:0] s
  );
    window_result_t r;
    int             quot;
    if (win_fill >= window_span(win_len)) begin
      win_sum  = win_sum - int'(win_ring[win_head]);
      win_head = win_head + 1'b1;
      win_fill = win_fill - 1;
    end
    win_ring[win_tail] = s;
    win_tail = win_tail + 1'b1;
    win_sum  = win_sum + int'(s);
    win_fill = win_fill + 1;
    quot     = win_sum / win_fill;   // SV division truncates toward zero
    r.total  = swsa_pkg::TOT_W'(win_sum);
    r.mean   = swsa_pkg::MEAN_W'(quot);
    r.fill   = swsa_pkg::LEN_W'(win_fill);
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Beat monitor: all handshakes are seen at the rising edge.
  // ---------------------------------------------------------------------------
  int in_beats;
  int out_beats;
  int mismatches;
  int idle_cycles;
  int total_lo;
  int total_hi;

  // Payload side data that travels with the beat on the sample channel.
  bit             beat_typed;
  window_result_t beat_exp;

  task automatic check_field(input string fname, input logic signed [31:0] want,
                             input logic signed [31:0] seen);
    if (want !== seen) begin
      mismatches++;
      $display("%0t ns: %s expected %0d, got %0d", $time, fname, want, seen);
    end
  endtask

  always @(posedge clk) begin
    window_result_t want;
    bit             moved;
    moved = 1'b0;
    if (rst_n) begin
      if (cfg_we) load_window_len(cfg_wdata);

      if (smp_bus.valid && smp_bus.ready) begin
        want = advance_window(smp_bus.sample);
        if (beat_typed) want = beat_exp;
        expected_results.push_back(want);
        in_beats++;
        moved = 1'b1;
      end

      if (res_bus.valid && res_bus.ready) begin
        out_beats++;
        moved = 1'b1;
        if (expected_results.size() == 0) begin
          mismatches++;
          $display("%0t ns: result beat with nothing expected, total %0d",
                   $time, res_bus.window_total);
        end else begin
          want = expected_results.pop_front();
          check_field("window_total", want.total, res_bus.window_total);
          check_field("window_mean",  want.mean,  res_bus.window_mean);
          check_field("fill_level",   want.fill,  res_bus.fill_level);
          if (int'(res_bus.window_total) < total_lo) total_lo = int'(res_bus.window_total);
          if (int'(res_bus.window_total) > total_hi) total_hi = int'(res_bus.window_total);
        end
      end
    end
    idle_cycles = moved ? 0 : idle_cycles + 1;
  end

  initial begin
    while (idle_cycles < WATCHDOG_LIMIT) @(negedge clk);
    $display("watchdog: no beat moved for %0d cycles", WATCHDOG_LIMIT);
    $display("tb_top NOT OK");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Result sink: random back-pressure, mostly short stalls, now and then long.
  // ---------------------------------------------------------------------------
  bit stalls_on;
  int stall_left;

  always @(negedge clk) begin
    if (stall_left == 0 && stalls_on && $urandom_range(99) < 25)
      stall_left = ($urandom_range(99) < 85) ? $urandom_range(3, 1) : $urandom_range(40, 8);
    if (stall_left > 0) begin
      res_bus.ready = 1'b0;
      stall_left--;
    end else begin
      res_bus.ready = 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // Sample driver. Everything is driven at the falling edge.
  // ---------------------------------------------------------------------------
  bit                                gaps_on;
  logic signed [swsa_pkg::SMP_W-1:0] last_sample;
  stim_row_t                         directed_rows [$];
  int                                settings_used;

  function automatic void add_row(input row_kind_e kind, input int val, input int rep,
                                  input bit typed, input int tot, input int avg,
                                  input int fill);
    stim_row_t row;
    row.kind      = kind;
    row.len       = swsa_pkg::LEN_W'(val);
    row.value     = swsa_pkg::SMP_W'(val);
    row.rep       = rep;
    row.typed     = typed;
    row.exp.total = swsa_pkg::TOT_W'(tot);
    row.exp.mean  = swsa_pkg::MEAN_W'(avg);
    row.exp.fill  = swsa_pkg::LEN_W'(fill);
    directed_rows.push_back(row);
  endfunction

  // Holds valid until the beat is taken; returns on the falling edge after it.
  task automatic send_sample(input logic signed [swsa_pkg::SMP_W-1:0] v, input bit typed,
                             input window_result_t want);
    int seen;
    seen           = in_beats;
    smp_bus.valid  = 1'b1;
    smp_bus.sample = v;
    beat_typed     = typed;
    beat_exp       = want;
    last_sample    = v;
    do @(negedge clk); while (in_beats == seen);
  endtask

  task automatic sender_gap();
    int g;
    g = 0;
    if (gaps_on && $urandom_range(99) >= 60)
      g = ($urandom_range(99) < 80) ? $urandom_range(3, 1) : $urandom_range(40, 8);
    if (g > 0) begin
      smp_bus.valid = 1'b0;
      repeat (g) @(negedge clk);
    end
  endtask

  // Stop sending until every result is back; optionally let the core go quiet.
  task automatic settle(input bit extra);
    smp_bus.valid = 1'b0;
    while (expected_results.size() != 0) @(negedge clk);
    if (extra) repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_window_len(input logic [swsa_pkg::LEN_W-1:0] len);
    settle(1'b1);
    cfg_we    = 1'b1;
    cfg_wdata = len;
    @(negedge clk);
    cfg_we    = 1'b0;
    settings_used++;
  endtask

  function automatic logic signed [swsa_pkg::SMP_W-1:0] pick_sample();
    int r;
    r = $urandom_range(99);
    if (r < 55) return swsa_pkg::SMP_W'($urandom);
    if (r < 70) return $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
    if (r < 85) return swsa_pkg::SMP_W'(int'($urandom_range(512)) - 256);
    return last_sample;
  endfunction

  initial begin
    int                                fixed_lens [9];
    int                                p;
    int                                k;
    int                                run_len;
    logic [swsa_pkg::LEN_W-1:0]        setting;
    logic signed [swsa_pkg::SMP_W-1:0] run_val;
    logic signed [swsa_pkg::SMP_W-1:0] v;

    fixed_lens = '{16, 31, 0, 1, 17, 2, 15, 8, 16};
    smp_bus.valid  = 1'b0;
    smp_bus.sample = '0;
    res_bus.ready  = 1'b0;
    cfg_we         = 1'b0;
    cfg_wdata      = '0;
    beat_typed     = 1'b0;
    beat_exp       = '0;
    last_sample    = '0;
    total_lo       = 0;
    total_hi       = 0;
    load_window_len(swsa_pkg::LEN_RESET);

    // Directed table. Reset length is 10.
    add_row(ROW_SAMPLE,  32767, 1, 1'b1,  32767,  32767, 1);
    add_row(ROW_SAMPLE, -32768, 1, 1'b1,     -1,      0, 2);  // mean -1/2 truncates to 0
    add_row(ROW_SAMPLE,      1, 1, 1'b1,      0,      0, 3);
    add_row(ROW_CFG,         1, 1, 1'b0,      0,      0, 0);  // shortest window
    add_row(ROW_SAMPLE, -32768, 1, 1'b1, -32768, -32768, 1);
    add_row(ROW_SAMPLE,  32767, 1, 1'b1,  32767,  32767, 1);  // evicts previous
    add_row(ROW_CFG,         0, 1, 1'b0,      0,      0, 0);  // zero acts as one
    add_row(ROW_SAMPLE,      5, 1, 1'b1,      5,      5, 1);
    add_row(ROW_CFG,         2, 1, 1'b0,      0,      0, 0);
    add_row(ROW_SAMPLE,     -3, 1, 1'b1,     -3,     -3, 1);
    add_row(ROW_SAMPLE,     -4, 1, 1'b1,     -7,     -3, 2);  // negative mean toward zero
    add_row(ROW_SAMPLE,    100, 1, 1'b0,      0,      0, 0);
    add_row(ROW_CFG,        31, 1, 1'b0,      0,      0, 0);  // clamps to ring depth
    add_row(ROW_SAMPLE, -32768, 16, 1'b0,     0,      0, 0);  // full ring, most negative sum
    add_row(ROW_SAMPLE,  32767, 1, 1'b1, -458753, -28672, 16); // eviction at full depth

    gaps_on   = 1'b1;
    stalls_on = 1'b1;
    repeat (2) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_CFG) begin
        write_window_len(directed_rows[i].len);
      end else begin
        for (k = 0; k < directed_rows[i].rep; k++) begin
          send_sample(directed_rows[i].value,
                      directed_rows[i].typed && (k == directed_rows[i].rep - 1),
                      directed_rows[i].exp);
          sender_gap();
        end
      end
    end

    // Random phases, each under its own window length.
    for (p = 0; p < PHASES; p++) begin
      if (p < 9) setting = swsa_pkg::LEN_W'(fixed_lens[p]);
      else if (p % 2 == 1) setting = swsa_pkg::LEN_W'($urandom_range(31));
      else setting = swsa_pkg::LEN_W'($urandom_range(16, 1));
      write_window_len(setting);

      gaps_on   = (p % 3 != 1) && (p % 4 != 3);
      stalls_on = (p % 3 != 2) && (p % 4 != 3);
      // Open with a run of one extreme to push the sum to its limit.
      run_len = window_span(setting) + 2;
      run_val = (p % 2 == 1) ? 16'sh8000 : 16'sh7FFF;

      for (k = 0; k < PHASE_BEATS; k++) begin
        v = (k < run_len) ? run_val : pick_sample();
        if ((p == 3 && k == 40) || $urandom_range(99) < 2) settle(1'b0);
        send_sample(v, 1'b0, '0);
        sender_gap();
      end
    end

    settle(1'b1);
    $display("run covered %0d samples under %0d window lengths (clamped ones too)",
             in_beats, settings_used + 1);
    $display("%0d results checked, window_total seen from %0d to %0d",
             out_beats, total_lo, total_hi);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
